@@ rtl/tvo_pkg.sv @@
`default_nettype none

package tvo_pkg;

  localparam int SINE_TABLE_ENTRIES = 256;
  localparam int VOICE_COUNT = 3;
  localparam int PHASE_W = 32;
  localparam int WAVE_W = 17;
  localparam int SAMPLE_W = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [31:0] STEP_RESET = 32'd27839174;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic signed [15:0] GAIN_Q15 = 16'sd22938;

  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP_1 = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP_2 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP_3 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_WAVEFORM_SELECT = 3'd3;

  typedef enum logic [2:0] {
    WAVE_SINE     = 3'd0,
    WAVE_TRIANGLE = 3'd1,
    WAVE_SAW      = 3'd2,
    WAVE_RAMP     = 3'd3,
    WAVE_SQUARE   = 3'd4
  } wave_sel_t;

  typedef logic signed [WAVE_W-1:0] wave_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;

  localparam logic [63:0] TAYLOR_DIV [1:6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

  // Quarter-wave sine entry for an angle x in Q30, evaluated by a truncated
  // Taylor series and rounded to Q15.
  function automatic logic [15:0] sine_entry(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic [63:0] v;
    x2 = (x * x) >> 30;
    term = x;
    sum = $signed(x);
    for (int k = 1; k <= 6; k++) begin
      term = (term * x2) >> 30;
      term = term / TAYLOR_DIV[k];
      if ((k % 2) == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    v = (64'(sum) * 64'd32768 + (64'd1 << 29)) >> 30;
    if (v > 64'd32768) begin
      v = 64'd32768;
    end
    return v[15:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/tvo_wave.sv @@
`default_nettype none

module tvo_wave import tvo_pkg::*; #(
  parameter int SineTableEntries = SINE_TABLE_ENTRIES
) (
  input  wire logic [PHASE_W-1:0] phase,
  input  wire logic [2:0]         sel,
  output wave_t                   wave
);

  localparam int IdxW = $clog2(SineTableEntries + 1);
  localparam int ProdW = 30 + IdxW;

  logic [15:0] sine_rom [0:SineTableEntries];

  for (genvar i = 0; i <= SineTableEntries; i++) begin : g_rom
    localparam logic [63:0] Angle = (HALF_PI_Q30 * 64'(i)) / 64'(SineTableEntries);
    localparam logic [15:0] Entry = sine_entry(Angle);
    assign sine_rom[i] = Entry;
  end

  logic [ProdW-1:0] idx_prod;
  logic [IdxW-1:0]  idx_raw;
  logic [IdxW-1:0]  idx;
  wave_t            sine_mag;
  wave_t            p16;
  wave_t            centered;
  wave_t            tri_abs;
  logic signed [WAVE_W:0] tri_wide;

  always_comb begin
    idx_prod = ProdW'(phase[29:0]) * ProdW'(SineTableEntries);
    idx_raw = idx_prod[ProdW-1:30];
    idx = phase[30] ? (IdxW'(SineTableEntries) - idx_raw) : idx_raw;
    sine_mag = $signed({1'b0, sine_rom[idx]});

    p16 = $signed({1'b0, phase[31:16]});
    centered = p16 - wave_t'(32768);
    tri_abs = centered[WAVE_W-1] ? -centered : centered;
    tri_wide = {tri_abs, 1'b0} - (WAVE_W+1)'(32768);

    case (wave_sel_t'(sel))
      WAVE_SINE:     wave = phase[31] ? -sine_mag : sine_mag;
      WAVE_TRIANGLE: wave = tri_wide[WAVE_W-1:0];
      WAVE_SAW:      wave = wave_t'(32768) - p16;
      WAVE_RAMP:     wave = centered;
      WAVE_SQUARE:   wave = phase[31] ? -wave_t'(32768) : wave_t'(32768);
      default:       wave = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/tvo_gain.sv @@
`default_nettype none

module tvo_gain import tvo_pkg::*; (
  input  wire wave_t wave,
  output sample_t    sample
);

  logic signed [31:0] prod;
  logic [31:0]        mag;
  logic [31:0]        rounded;
  logic [SAMPLE_W-1:0] r;

  always_comb begin
    prod = 32'(wave) * 32'(GAIN_Q15);
    mag = prod[31] ? 32'(-prod) : 32'(prod);
    rounded = (mag + 32'd16384) >> 15;
    r = rounded[SAMPLE_W-1:0];
    sample = prod[31] ? -$signed(r) : $signed(r);
  end

endmodule

`default_nettype wire

@@ rtl/three_voice_waveform_oscillator.sv @@
`default_nettype none

// Three phase-accumulator voices sharing one waveform setting. Each accepted
// beat renders one frame: the voices are evaluated at their current phases,
// scaled by 0.7, and returned with a mix equal to their sum times 0.25, all
// signed Q1.15. The block takes one frame per clock while the output beat
// is taken. The phase stage is loaded at acceptance; the result then passes
// a waveform stage, a gain stage and the output register; a full pipeline
// stalls only when the output beat is not taken. The phase accumulators
// advance at acceptance, so frame order is kept across stalls. Configuration
// writes are accepted in every cycle and must be issued while no frame is in
// flight.
module three_voice_waveform_oscillator import tvo_pkg::*; #(
  parameter int SineTableEntries = SINE_TABLE_ENTRIES
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   frame_tick,
  input  wire logic                   restart,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output sample_t                     voice1_sample,
  output sample_t                     voice2_sample,
  output sample_t                     voice3_sample,
  output sample_t                     mix_sample,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [PHASE_W-1:0] phase_step [VOICE_COUNT];
  logic [2:0]         waveform_select;
  logic [PHASE_W-1:0] voice_phase [VOICE_COUNT];

  logic               v1, v2, v3;
  logic [PHASE_W-1:0] s1_phase [VOICE_COUNT];
  wave_t              s2_wave [VOICE_COUNT];
  sample_t            s3_sample [VOICE_COUNT];

  logic en1, en2, en3, en4;
  logic accept;
  logic tick_seen;

  wave_t   wave_c [VOICE_COUNT];
  sample_t sample_c [VOICE_COUNT];
  logic signed [SAMPLE_W+1:0] mix_sum;
  logic [SAMPLE_W+1:0]        mix_mag;
  logic [SAMPLE_W+1:0]        mix_round;
  logic [SAMPLE_W-1:0]        mix_r;
  sample_t                    mix_c;

  assign en4 = !out_valid || out_ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_ready = en1;
  assign accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  for (genvar i = 0; i < VOICE_COUNT; i++) begin : g_voice
    tvo_wave #(
      .SineTableEntries(SineTableEntries)
    ) u_wave (
      .phase(s1_phase[i]),
      .sel  (waveform_select),
      .wave (wave_c[i])
    );

    tvo_gain u_gain (
      .wave  (s2_wave[i]),
      .sample(sample_c[i])
    );
  end

  always_comb begin
    mix_sum = (SAMPLE_W+2)'(s3_sample[0]) + (SAMPLE_W+2)'(s3_sample[1])
            + (SAMPLE_W+2)'(s3_sample[2]);
    mix_mag = mix_sum[SAMPLE_W+1] ? (SAMPLE_W+2)'(-mix_sum) : (SAMPLE_W+2)'(mix_sum);
    mix_round = (mix_mag + (SAMPLE_W+2)'(2)) >> 2;
    mix_r = mix_round[SAMPLE_W-1:0];
    mix_c = mix_sum[SAMPLE_W+1] ? -$signed(mix_r) : $signed(mix_r);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < VOICE_COUNT; i++) begin
        phase_step[i] <= STEP_RESET;
        voice_phase[i] <= '0;
      end
      waveform_select <= WAVE_SINE;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
      tick_seen <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PHASE_STEP_1:    phase_step[0] <= cfg_data;
          REG_PHASE_STEP_2:    phase_step[1] <= cfg_data;
          REG_PHASE_STEP_3:    phase_step[2] <= cfg_data;
          REG_WAVEFORM_SELECT: waveform_select <= cfg_data[2:0];
          default: ;
        endcase
      end
      if (accept) begin
        // The tick flag carries no information; every beat renders a frame.
        tick_seen <= frame_tick;
        for (int i = 0; i < VOICE_COUNT; i++) begin
          if (restart) begin
            voice_phase[i] <= phase_step[i];
          end else begin
            voice_phase[i] <= voice_phase[i] + phase_step[i];
          end
        end
      end
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < VOICE_COUNT; i++) begin
        s1_phase[i] <= restart ? '0 : voice_phase[i];
      end
    end
    if (en2 && v1) begin
      for (int i = 0; i < VOICE_COUNT; i++) begin
        s2_wave[i] <= wave_c[i];
      end
    end
    if (en3 && v2) begin
      for (int i = 0; i < VOICE_COUNT; i++) begin
        s3_sample[i] <= sample_c[i];
      end
    end
    if (en4 && v3) begin
      voice1_sample <= s3_sample[0];
      voice2_sample <= s3_sample[1];
      voice3_sample <= s3_sample[2];
      mix_sample <= mix_c;
    end
  end

endmodule

`default_nettype wire
